### hdl/hdsl_pkg.sv
package hdsl_pkg;

   localparam int unsigned CHOP_PERIOD = 65;
   localparam int unsigned NTC_LEN = 32;
   localparam logic [4:0] SAFETY_RELOAD = 5'd20;
   localparam logic [22:0] FAST_LIMIT_X100 = 23'd550;
   localparam logic [6:0] HOT_HANDLE_C = 7'd85;
   localparam logic [6:0] SLOW_MARGIN_C = 7'd5;
   localparam logic [8:0] DUTY_FULL = 9'd256;
   localparam logic [8:0] DUTY_MIN = 9'd8;

   localparam logic [1:0] KIND_UPDATE = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_WINDOW = 2'd2;

   localparam logic [1:0] REG_VDIV = 2'd0;
   localparam logic [1:0] REG_PLIM = 2'd1;
   localparam logic [1:0] REG_SLOW_LO = 2'd2;
   localparam logic [1:0] REG_SLOW_HI = 2'd3;

   localparam logic [1:0] PH_VOLTS = 2'd0;
   localparam logic [1:0] PH_CUR = 2'd1;
   localparam logic [1:0] PH_USER = 2'd2;
   localparam logic [1:0] PH_DUTY = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  pulse;
      logic [14:0] vin_adc;
      logic [7:0]  tip_ohms_x10;
      logic [15:0] source_amps_x100;
      logic        source_valid;
      logic        on_dc;
      logic [14:0] handle_adc;
   } req_type;

   typedef struct packed {
      logic [6:0] compare_ticks;
      logic [6:0] prescaler_out;
      logic [8:0] duty_x256_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_STORE,
      ST_FINISH,
      ST_DONE
   } state_type;

   function automatic logic [14:0] ntc_adc(input logic [4:0] idx);
      logic [14:0] v;
      unique case (idx)
         5'd0: v = 15'd23931;   5'd1: v = 15'd23210;   5'd2: v = 15'd22466;
         5'd3: v = 15'd21703;   5'd4: v = 15'd20924;   5'd5: v = 15'd20135;
         5'd6: v = 15'd19338;   5'd7: v = 15'd18538;   5'd8: v = 15'd17738;
         5'd9: v = 15'd16943;   5'd10: v = 15'd16156;  5'd11: v = 15'd15381;
         5'd12: v = 15'd14621;  5'd13: v = 15'd13878;  5'd14: v = 15'd13155;
         5'd15: v = 15'd12455;  5'd16: v = 15'd11778;  5'd17: v = 15'd11126;
         5'd18: v = 15'd10501;  5'd19: v = 15'd9902;   5'd20: v = 15'd9330;
         5'd21: v = 15'd8786;   5'd22: v = 15'd8269;   5'd23: v = 15'd7313;
         5'd24: v = 15'd6460;   5'd25: v = 15'd5702;   5'd26: v = 15'd5031;
         5'd27: v = 15'd4440;   5'd28: v = 15'd3921;   5'd29: v = 15'd3465;
         5'd30: v = 15'd3065;   5'd31: v = 15'd2715;
         default: v = 15'd2715;
      endcase
      return v;
   endfunction

   function automatic logic [6:0] ntc_deg(input logic [4:0] idx);
      logic [6:0] d;
      if (idx < 5'd23) begin
         d = {1'b0, idx, 1'b0};
      end else begin
         d = 7'(7'd48 + 7'({2'b0, idx - 5'd23} << 2));
      end
      return d;
   endfunction

   function automatic logic [6:0] presc_of(input logic [2:0] step);
      logic [6:0] p;
      unique case (step)
         3'd0: p = 7'd10;
         3'd1: p = 7'd20;
         3'd2: p = 7'd40;
         3'd3: p = 7'd50;
         default: p = 7'd80;
      endcase
      return p;
   endfunction

endpackage

### hdl/heater_duty_supply_limiter_unit.sv
// Control update (kind 0): result from four 32-bit passes of one shared
// bit-serial restoring divider, each with load, divide and store steps, then a finish step.
// Period tick, window end and unused kind skip the divider and go straight to the done state.
// One beat in flight at a time; the next beat is taken the cycle after the result loads.
// Synchronous active-high reset restores state and control registers; datapath and result registers have no reset.
module heater_duty_supply_limiter_unit #(
   parameter int unsigned NTC_ROWS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hdsl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hdsl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_data
);
   import hdsl_pkg::*;

   localparam int unsigned ROW_LIM = (NTC_ROWS < NTC_LEN) ? NTC_ROWS : NTC_LEN;
   localparam int unsigned DIV_W = 32;

   state_type state_ff, state_in;

   logic [9:0]  vdiv_ff;
   logic [7:0]  plim_ff;
   logic [6:0]  slow_lo_ff, slow_hi_ff;

   logic [4:0]  safety_ff;
   logic [7:0]  pend_ff;
   logic [6:0]  cap_ff;
   logic [8:0]  latched_ff;
   logic [1:0]  tstep_ff;
   logic [6:0]  presc_ff;
   logic [6:0]  compare_ff;

   req_type     req_ff;
   logic [1:0]  phase_ff;
   logic [4:0]  bit_ff;
   logic [DIV_W-1:0] num_ff, rem_ff, den_ff;
   logic [15:0] volts_ff;
   logic [22:0] cur_ff;
   logic [17:0] limit_ff;
   logic [8:0]  duty_ff;

   logic [5:0]  row_ff;
   logic        found_ff;
   logic [6:0]  temp_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        accept, out_load;
   logic [DIV_W:0] trial;
   logic [4:0]  safety_dec;
   logic [5:0]  pulse_q;
   logic [6:0]  tick_cmp;
   logic [17:0] user_w, base_lim;
   logic [1:0]  tstep_in;
   logic [15:0] cap_prod;
   logic [6:0]  cap_in;
   logic [2:0]  base_step, step_sum;

   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.kind == KIND_UPDATE) ? ST_LOAD : ST_DONE;
            end
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (bit_ff == 5'(DIV_W - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: state_in = (phase_ff == PH_DUTY) ? ST_FINISH : ST_LOAD;
         ST_FINISH: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      trial = {rem_ff, num_ff[DIV_W-1]} - {1'b0, den_ff};
      safety_dec = (safety_ff == 5'd0) ? 5'd0 : 5'(safety_ff - 5'd1);
      pulse_q = pend_ff[7:2];
      tick_cmp = ({1'b0, pulse_q} > cap_ff) ? cap_ff : {1'b0, pulse_q};
      user_w = num_ff[17:0];
      base_lim = (!req_ff.on_dc && req_ff.source_valid) ?
                 {2'b0, req_ff.source_amps_x100} : 18'd0;
      cap_prod = 16'(duty_ff * 16'(CHOP_PERIOD));
      if (duty_ff >= DUTY_FULL) begin
         cap_in = 7'(CHOP_PERIOD);
      end else if (cap_prod[15:8] == 8'd0) begin
         cap_in = 7'd1;
      end else begin
         cap_in = cap_prod[14:8];
      end
      tstep_in = tstep_ff;
      priority if (tstep_ff == 2'd0 && temp_ff >= slow_lo_ff) begin
         tstep_in = 2'd1;
      end else if (tstep_ff == 2'd1 && temp_ff >= slow_hi_ff) begin
         tstep_in = 2'd2;
      end else if (tstep_ff == 2'd2 && 8'(temp_ff) + 8'(SLOW_MARGIN_C) < 8'(slow_hi_ff)) begin
         tstep_in = 2'd1;
      end else if (tstep_ff == 2'd1 && 8'(temp_ff) + 8'(SLOW_MARGIN_C) < 8'(slow_lo_ff)) begin
         tstep_in = 2'd0;
      end
      base_step = (duty_ff >= DUTY_FULL || req_ff.on_dc) ? 3'd3 :
                  ((cur_ff > FAST_LIMIT_X100) ? 3'd1 : 3'd0);
      step_sum = 3'(base_step + {1'b0, tstep_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vdiv_ff <= 10'd467;
         plim_ff <= 8'd0;
         slow_lo_ff <= 7'd50;
         slow_hi_ff <= 7'd60;
         safety_ff <= 5'd0;
         pend_ff <= 8'd0;
         cap_ff <= 7'(CHOP_PERIOD);
         latched_ff <= DUTY_FULL;
         tstep_ff <= 2'd0;
         presc_ff <= 7'd50;
         compare_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b1;
         row_ff <= 6'd0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_VDIV: vdiv_ff <= csr_data;
               REG_PLIM: plim_ff <= csr_data[7:0];
               REG_SLOW_LO: slow_lo_ff <= csr_data[6:0];
               REG_SLOW_HI: slow_hi_ff <= csr_data[6:0];
               default: vdiv_ff <= vdiv_ff;
            endcase
         end
         if (accept) begin
            unique case (req_data.kind)
               KIND_UPDATE: begin
                  safety_ff <= SAFETY_RELOAD;
                  pend_ff <= req_data.pulse;
                  found_ff <= 1'b0;
                  row_ff <= 6'd0;
               end
               KIND_TICK: begin
                  safety_ff <= safety_dec;
                  compare_ff <= (safety_dec == 5'd0) ? 7'd0 : tick_cmp;
               end
               KIND_WINDOW: compare_ff <= 7'd0;
               default: compare_ff <= compare_ff;
            endcase
         end else if (!found_ff) begin
            if (row_ff >= 6'(ROW_LIM)) begin
               found_ff <= 1'b1;
            end else begin
               if (req_ff.handle_adc > ntc_adc(row_ff[4:0])) begin
                  found_ff <= 1'b1;
               end
               row_ff <= 6'(row_ff + 6'd1);
            end
         end
         if (state_ff == ST_FINISH) begin
            latched_ff <= duty_ff;
            cap_ff <= cap_in;
            tstep_ff <= tstep_in;
            presc_ff <= presc_of((step_sum > 3'd4) ? 3'd4 : step_sum);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
         phase_ff <= PH_VOLTS;
         temp_ff <= HOT_HANDLE_C;
      end
      if (!found_ff && !accept && row_ff < 6'(ROW_LIM)
          && req_ff.handle_adc > ntc_adc(row_ff[4:0])) begin
         temp_ff <= ntc_deg(row_ff[4:0]);
      end
      unique case (state_ff)
         ST_LOAD: begin
            bit_ff <= 5'd0;
            rem_ff <= '0;
            unique case (phase_ff)
               PH_VOLTS: begin
                  num_ff <= DIV_W'({req_ff.vin_adc, 2'b00});
                  den_ff <= DIV_W'(vdiv_ff);
               end
               PH_CUR: begin
                  num_ff <= DIV_W'(volts_ff * 23'd100);
                  den_ff <= DIV_W'(req_ff.tip_ohms_x10);
               end
               PH_USER: begin
                  num_ff <= DIV_W'(plim_ff * 18'd1000);
                  den_ff <= DIV_W'(volts_ff);
               end
               PH_DUTY: begin
                  num_ff <= DIV_W'(limit_ff * 30'd2304);
                  den_ff <= DIV_W'(cur_ff * 27'd10);
               end
               default: num_ff <= num_ff;
            endcase
         end
         ST_DIV: begin
            bit_ff <= 5'(bit_ff + 5'd1);
            if (!trial[DIV_W]) begin
               rem_ff <= trial[DIV_W-1:0];
            end else begin
               rem_ff <= {rem_ff[DIV_W-2:0], num_ff[DIV_W-1]};
            end
            num_ff <= {num_ff[DIV_W-2:0], !trial[DIV_W]};
         end
         ST_STORE: begin
            phase_ff <= 2'(phase_ff + 2'd1);
            unique case (phase_ff)
               PH_VOLTS: begin
                  if (vdiv_ff == 10'd0) begin
                     volts_ff <= 16'd0;
                  end else if (num_ff[DIV_W-1:16] != '0) begin
                     volts_ff <= 16'hFFFF;
                  end else begin
                     volts_ff <= num_ff[15:0];
                  end
               end
               PH_CUR: begin
                  cur_ff <= (req_ff.tip_ohms_x10 == 8'd0 || volts_ff == 16'd0) ?
                            23'd0 : num_ff[22:0];
               end
               PH_USER: begin
                  if (plim_ff != 8'd0 && volts_ff != 16'd0
                      && (base_lim == 18'd0 || user_w < base_lim)) begin
                     limit_ff <= user_w;
                  end else begin
                     limit_ff <= base_lim;
                  end
               end
               PH_DUTY: begin
                  if (limit_ff != 18'd0 && cur_ff > 23'(limit_ff)) begin
                     duty_ff <= (num_ff[8:0] < DUTY_MIN) ? DUTY_MIN : num_ff[8:0];
                  end else begin
                     duty_ff <= DUTY_FULL;
                  end
               end
               default: phase_ff <= phase_ff;
            endcase
         end
         default: bit_ff <= bit_ff;
      endcase
      if (out_load) begin
         rsp_ff.compare_ticks <= compare_ff;
         rsp_ff.prescaler_out <= presc_ff;
         rsp_ff.duty_x256_out <= latched_ff;
      end
   end

endmodule

### hdl/hdsl_checker.sv
module hdsl_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hdsl_pkg::rsp_type rsp_data
);
   import hdsl_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.prescaler_out == 7'd10 || rsp_data.prescaler_out == 7'd20
         || rsp_data.prescaler_out == 7'd40 || rsp_data.prescaler_out == 7'd50
         || rsp_data.prescaler_out == 7'd80)
      else $error("prescaler outside table");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.duty_x256_out >= DUTY_MIN
         && rsp_data.duty_x256_out <= DUTY_FULL)
      else $error("duty out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.compare_ticks <= 7'(CHOP_PERIOD))
      else $error("compare exceeds chop period");

endmodule

bind heater_duty_supply_limiter_unit hdsl_checker u_hdsl_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import hdsl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [9:0] csr_data = '0;

   heater_duty_supply_limiter_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // predictor state
   int unsigned vdiv_q, plim_q, slow_lo_q, slow_hi_q;
   int unsigned safety_q, pulse_q, cap_q, duty_q, tstep_q, presc_q, cmp_q;
   rsp_type expected_q[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit sender_busy = 1'b0;

   const int unsigned NTC_ADC_TAB[32] = '{
      23931, 23210, 22466, 21703, 20924, 20135, 19338, 18538,
      17738, 16943, 16156, 15381, 14621, 13878, 13155, 12455,
      11778, 11126, 10501, 9902, 9330, 8786, 8269, 7313,
      6460, 5702, 5031, 4440, 3921, 3465, 3065, 2715};
   const int unsigned NTC_DEG_TAB[32] = '{
      0, 2, 4, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26, 28, 30,
      32, 34, 36, 38, 40, 42, 44, 48, 52, 56, 60, 64, 68, 72, 76, 80};
   const int unsigned PRESC_TAB[5] = '{10, 20, 40, 50, 80};

   task automatic model_reset();
      vdiv_q = 467; plim_q = 0; slow_lo_q = 50; slow_hi_q = 60;
      safety_q = 0; pulse_q = 0; cap_q = CHOP_PERIOD; duty_q = 256;
      tstep_q = 0; presc_q = 50; cmp_q = 0;
   endtask

   function automatic int handle_temp(int unsigned adc);
      for (int i = 0; i < 32; i++) begin
         if (adc > NTC_ADC_TAB[i]) return NTC_DEG_TAB[i];
      end
      return 85;
   endfunction

   function automatic void apply_update(req_type r);
      longint unsigned volts, cur, lim, duty, cap, user;
      int t;
      int unsigned step;
      volts = 0; cur = 0; lim = 0; duty = 256; cap = CHOP_PERIOD;
      if (vdiv_q != 0) begin
         volts = (longint'(r.vin_adc) * 4) / vdiv_q;
         if (volts > 65535) volts = 65535;
      end
      if (r.tip_ohms_x10 != 0 && volts != 0) cur = (volts * 100) / r.tip_ohms_x10;
      if (!r.on_dc && r.source_valid) lim = r.source_amps_x100;
      if (plim_q != 0 && volts != 0) begin
         user = (longint'(plim_q) * 1000) / volts;
         if (lim == 0 || user < lim) lim = user;
      end
      if (lim != 0 && cur > lim) begin
         duty = (lim * 256 * 9) / (cur * 10);
         if (duty < 8) duty = 8;
      end
      duty_q = duty;
      if (duty < 256) begin
         cap = (duty * CHOP_PERIOD) / 256;
         if (cap < 1) cap = 1;
      end
      cap_q = cap;
      step = (duty >= 256 || r.on_dc) ? 3 : (cur > 550 ? 1 : 0);
      t = handle_temp(r.handle_adc);
      if (tstep_q == 0 && t >= int'(slow_lo_q)) tstep_q = 1;
      else if (tstep_q == 1 && t >= int'(slow_hi_q)) tstep_q = 2;
      else if (tstep_q == 2 && t < int'(slow_hi_q) - 5) tstep_q = 1;
      else if (tstep_q == 1 && t < int'(slow_lo_q) - 5) tstep_q = 0;
      step += tstep_q;
      if (step > 4) step = 4;
      presc_q = PRESC_TAB[step];
   endfunction

   function automatic rsp_type predict_limiter(req_type r);
      rsp_type o;
      int unsigned d;
      if (r.kind == KIND_UPDATE) begin
         safety_q = SAFETY_RELOAD;
         pulse_q = r.pulse;
         apply_update(r);
      end else if (r.kind == KIND_TICK) begin
         if (safety_q != 0) safety_q--;
         if (safety_q == 0) cmp_q = 0;
         else begin
            d = pulse_q / 4;
            if (d > cap_q) d = cap_q;
            cmp_q = d;
         end
      end else if (r.kind == KIND_WINDOW) begin
         cmp_q = 0;
      end
      o.compare_ticks = 7'(cmp_q);
      o.prescaler_out = 7'(presc_q);
      o.duty_x256_out = 9'(duty_q);
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker with random stall bursts
   initial begin
      rsp_type want;
      int stall;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.compare_ticks !== want.compare_ticks)
                  report_mismatch("compare_ticks", rsp_data.compare_ticks, want.compare_ticks);
               if (rsp_data.prescaler_out !== want.prescaler_out)
                  report_mismatch("prescaler_out", rsp_data.prescaler_out, want.prescaler_out);
               if (rsp_data.duty_x256_out !== want.duty_x256_out)
                  report_mismatch("duty_x256_out", rsp_data.duty_x256_out, want.duty_x256_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready) || !sender_busy) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(req_type r);
      int gap;
      sender_busy = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(predict_limiter(r));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      csr_index <= idx;
      csr_data <= 10'(val);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_VDIV: vdiv_q = val & 10'h3ff;
         REG_PLIM: plim_q = val & 8'hff;
         REG_SLOW_LO: slow_lo_q = val & 7'h7f;
         default: slow_hi_q = val & 7'h7f;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type random_req(int kind_sel);
      req_type r;
      r = '0;
      r.kind = 2'(kind_sel);
      r.pulse = 8'($urandom);
      r.vin_adc = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(1500, 3000));
      r.tip_ohms_x10 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(20, 90));
      r.source_amps_x100 = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(100, 500));
      r.source_valid = 1'($urandom);
      r.on_dc = ($urandom_range(0, 3) == 0);
      r.handle_adc = ($urandom_range(0, 1) == 0) ? 15'($urandom)
                                                   : 15'($urandom_range(2000, 12000));
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      r = '0; r.kind = KIND_TICK; send_item(r);
      r = '1; r.kind = KIND_SPARE; send_item(r);
      r = '1; r.kind = KIND_UPDATE; send_item(r);
      r.kind = KIND_TICK; send_item(r);
      r = '0; r.kind = KIND_UPDATE; send_item(r);
      r.vin_adc = 15'h7fff; r.tip_ohms_x10 = 8'd1; r.source_valid = 1'b1;
      r.source_amps_x100 = 16'd1; r.pulse = 8'hff; r.handle_adc = 15'd0;
      send_item(r);
      r.kind = KIND_TICK; send_item(r);
      r.kind = KIND_WINDOW; send_item(r);
      r = '0; r.kind = KIND_UPDATE; r.vin_adc = 15'd2300; r.tip_ohms_x10 = 8'd40;
      r.source_valid = 1'b1; r.source_amps_x100 = 16'hffff; r.pulse = 8'd200;
      send_item(r);
      r.on_dc = 1'b1; send_item(r);
      r.on_dc = 1'b0; r.source_amps_x100 = 16'd300; r.handle_adc = 15'd3000;
      send_item(r);
      r.handle_adc = 15'd24000; send_item(r);
      repeat (21) begin
         r.kind = KIND_TICK; send_item(r);
         if (r.pulse == 0) break;
         r.pulse = 8'd0;
      end
   endtask

   task automatic test_config_extremes();
      req_type r;
      drain();
      write_reg(REG_VDIV, 0); write_reg(REG_PLIM, 255);
      write_reg(REG_SLOW_LO, 0); write_reg(REG_SLOW_HI, 120);
      repeat (12) send_item(random_req($urandom_range(0, 1) ? KIND_UPDATE : KIND_TICK));
      drain();
      write_reg(REG_VDIV, 1); write_reg(REG_PLIM, 1);
      write_reg(REG_SLOW_LO, 120); write_reg(REG_SLOW_HI, 0);
      r = random_req(KIND_UPDATE); r.vin_adc = 15'h7fff; send_item(r);
      repeat (12) send_item(random_req($urandom_range(0, 1) ? KIND_UPDATE : KIND_TICK));
      drain();
      write_reg(REG_VDIV, 1023); write_reg(REG_PLIM, 0);
      write_reg(REG_SLOW_LO, 3); write_reg(REG_SLOW_HI, 4);
      repeat (12) send_item(random_req($urandom_range(0, 2)));
   endtask

   task automatic test_random_phase(int count);
      int k;
      drain();
      write_reg(REG_VDIV, $urandom_range(150, 1000));
      write_reg(REG_PLIM, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255));
      write_reg(REG_SLOW_LO, $urandom_range(20, 80));
      write_reg(REG_SLOW_HI, $urandom_range(30, 100));
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 19);
         if (k < 5) send_item(random_req(KIND_UPDATE));
         else if (k < 17) send_item(random_req(KIND_TICK));
         else if (k < 19) send_item(random_req(KIND_WINDOW));
         else send_item(random_req(KIND_SPARE));
      end
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      for (int p = 0; p < 5; p++) test_random_phase(250);
      drain();
      quiet = 1'b1;
      test_random_phase(200);
      drain();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
